@@ hdl/lclp_pkg.sv @@
// Shared constants, event codes, keyword tables and compare result type
// for the line command LED parser. No dependencies.
package lclp_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int LEN_W         = $clog2(LINE_CAPACITY);

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_NUL = 8'd0;

  localparam logic [LEN_W-1:0] ON_LEN  = LEN_W'(2);
  localparam logic [LEN_W-1:0] OFF_LEN = LEN_W'(3);
  localparam logic [LEN_W-1:0] TOG_LEN = LEN_W'(6);

  typedef enum logic [1:0] {
    EV_LED  = 2'd0,
    EV_TEXT = 2'd1,
    EV_LONG = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic is_zero;
    logic eq_on;
    logic eq_off;
    logic eq_tog;
  } cmp_res_t;

  function automatic logic [7:0] kw_on(input logic [ADDR_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      ADDR_W'(0): ch = "O";
      ADDR_W'(1): ch = "N";
      default:    ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_off(input logic [ADDR_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      ADDR_W'(0): ch = "O";
      ADDR_W'(1): ch = "F";
      ADDR_W'(2): ch = "F";
      default:    ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_tog(input logic [ADDR_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      ADDR_W'(0): ch = "T";
      ADDR_W'(1): ch = "O";
      ADDR_W'(2): ch = "G";
      ADDR_W'(3): ch = "G";
      ADDR_W'(4): ch = "L";
      ADDR_W'(5): ch = "E";
      default:    ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

@@ hdl/line_command_led_parser.sv @@
// Top level of the line command LED parser: sequencer, line store and result register.
// Depends on lclp_pkg, lclp_ram and lclp_cmp.
//
//   channel | ports                                    | direction
//   in      | in_valid, in_stall, in_rx_byte           | byte items in
//   out     | out_valid, out_stall, out_event_kind,    | result items out
//           | out_led_level, out_text_byte,            |
//           | out_text_valid, out_last                 |
//
// A carriage return, a stored character or a discarded byte is handled while idle.
// A newline scans the line one stored character at a time through the one compare
// unit (read state, then check state), then passes the decision state; an echo reads
// each character and waits until it has left the result register before the next.
// Reset is synchronous and clears the sequencer, line length, discard flag and LED.
// The input is stalled while a line is processed and while a result waits.
module line_command_led_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic       out_led_level,
  output logic [7:0] out_text_byte,
  output logic       out_text_valid,
  output logic       out_last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DECIDE,
    ST_ECHO_RD,
    ST_ECHO_OUT,
    ST_ECHO_WAIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [lclp_pkg::LEN_W-1:0]  line_len_r, line_len_nxt;
  logic [lclp_pkg::LEN_W-1:0]  tlen_r, tlen_nxt;
  logic [lclp_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  logic                        discard_r, discard_nxt;
  logic                        led_r, led_nxt;
  logic                        on_ok_r, on_ok_nxt;
  logic                        off_ok_r, off_ok_nxt;
  logic                        tog_ok_r, tog_ok_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  kind_r, kind_nxt;
  logic                        lvl_r, lvl_nxt;
  logic [7:0]                  tbyte_r, tbyte_nxt;
  logic                        tvalid_r, tvalid_nxt;
  logic                        last_r, last_nxt;

  logic                        accept;
  logic                        ram_we;
  logic [lclp_pkg::ADDR_W-1:0] ram_addr;
  logic [7:0]                  ram_rdata;
  logic [lclp_pkg::LEN_W-1:0]  idx_inc;
  lclp_pkg::cmp_res_t          cmp;

  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;
  assign idx_inc  = lclp_pkg::LEN_W'(idx_r) + lclp_pkg::LEN_W'(1);

  assign ram_we = accept && !discard_r && (in_rx_byte != lclp_pkg::CH_CR) &&
                  (in_rx_byte != lclp_pkg::CH_LF) &&
                  (line_len_r != lclp_pkg::LEN_W'(lclp_pkg::STORE_DEPTH));
  assign ram_addr = ram_we ? line_len_r[lclp_pkg::ADDR_W-1:0] : idx_r;

  lclp_ram #(
    .WIDTH (8),
    .DEPTH (lclp_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_rx_byte),
    .rdata (ram_rdata)
  );

  lclp_cmp u_cmp (
    .ch  (ram_rdata),
    .idx (idx_r),
    .res (cmp)
  );

  always_comb begin
    state_nxt     = state_r;
    line_len_nxt  = line_len_r;
    tlen_nxt      = tlen_r;
    idx_nxt       = idx_r;
    discard_nxt   = discard_r;
    led_nxt       = led_r;
    on_ok_nxt     = on_ok_r;
    off_ok_nxt    = off_ok_r;
    tog_ok_nxt    = tog_ok_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    lvl_nxt       = lvl_r;
    tbyte_nxt     = tbyte_r;
    tvalid_nxt    = tvalid_r;
    last_nxt      = last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_rx_byte != lclp_pkg::CH_CR) begin
          if (discard_r) begin
            if (in_rx_byte == lclp_pkg::CH_LF) begin
              discard_nxt = 1'b0;
            end
          end else if (in_rx_byte != lclp_pkg::CH_LF) begin
            if (line_len_r == lclp_pkg::LEN_W'(lclp_pkg::STORE_DEPTH)) begin
              line_len_nxt  = '0;
              discard_nxt   = 1'b1;
              out_valid_nxt = 1'b1;
              kind_nxt      = lclp_pkg::EV_LONG;
              lvl_nxt       = led_r;
              tbyte_nxt     = lclp_pkg::CH_NUL;
              tvalid_nxt    = 1'b0;
              last_nxt      = 1'b1;
            end else begin
              line_len_nxt = line_len_r + lclp_pkg::LEN_W'(1);
            end
          end else begin
            idx_nxt    = '0;
            tlen_nxt   = '0;
            on_ok_nxt  = 1'b1;
            off_ok_nxt = 1'b1;
            tog_ok_nxt = 1'b1;
            state_nxt  = (line_len_r == '0) ? ST_DECIDE : ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (cmp.is_zero) begin
          tlen_nxt  = lclp_pkg::LEN_W'(idx_r);
          state_nxt = ST_DECIDE;
        end else begin
          on_ok_nxt  = on_ok_r && (cmp.eq_on || lclp_pkg::LEN_W'(idx_r) >= lclp_pkg::ON_LEN);
          off_ok_nxt = off_ok_r &&
                       (cmp.eq_off || lclp_pkg::LEN_W'(idx_r) >= lclp_pkg::OFF_LEN);
          tog_ok_nxt = tog_ok_r &&
                       (cmp.eq_tog || lclp_pkg::LEN_W'(idx_r) >= lclp_pkg::TOG_LEN);
          if (idx_inc == line_len_r) begin
            tlen_nxt  = idx_inc;
            state_nxt = ST_DECIDE;
          end else begin
            idx_nxt   = idx_inc[lclp_pkg::ADDR_W-1:0];
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_DECIDE: begin
        line_len_nxt = '0;
        idx_nxt      = '0;
        tbyte_nxt    = lclp_pkg::CH_NUL;
        tvalid_nxt   = 1'b0;
        last_nxt     = 1'b1;
        state_nxt    = ST_IDLE;
        if (tlen_r == lclp_pkg::ON_LEN && on_ok_r) begin
          led_nxt       = 1'b1;
          out_valid_nxt = 1'b1;
          kind_nxt      = lclp_pkg::EV_LED;
          lvl_nxt       = 1'b1;
        end else if (tlen_r == lclp_pkg::OFF_LEN && off_ok_r) begin
          led_nxt       = 1'b0;
          out_valid_nxt = 1'b1;
          kind_nxt      = lclp_pkg::EV_LED;
          lvl_nxt       = 1'b0;
        end else if (tlen_r == lclp_pkg::TOG_LEN && tog_ok_r) begin
          led_nxt       = !led_r;
          out_valid_nxt = 1'b1;
          kind_nxt      = lclp_pkg::EV_LED;
          lvl_nxt       = !led_r;
        end else if (tlen_r == '0) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = lclp_pkg::EV_TEXT;
          lvl_nxt       = led_r;
        end else begin
          state_nxt = ST_ECHO_RD;
        end
      end
      ST_ECHO_RD: begin
        state_nxt = ST_ECHO_OUT;
      end
      ST_ECHO_OUT: begin
        out_valid_nxt = 1'b1;
        kind_nxt      = lclp_pkg::EV_TEXT;
        lvl_nxt       = led_r;
        tbyte_nxt     = ram_rdata;
        tvalid_nxt    = 1'b1;
        last_nxt      = (idx_inc == tlen_r);
        state_nxt     = ST_ECHO_WAIT;
      end
      ST_ECHO_WAIT: begin
        if (!out_valid_r) begin
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_inc[lclp_pkg::ADDR_W-1:0];
            state_nxt = ST_ECHO_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_len_r  <= '0;
      discard_r   <= 1'b0;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_len_r  <= line_len_nxt;
      discard_r   <= discard_nxt;
      led_r       <= led_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tlen_r   <= tlen_nxt;
    idx_r    <= idx_nxt;
    on_ok_r  <= on_ok_nxt;
    off_ok_r <= off_ok_nxt;
    tog_ok_r <= tog_ok_nxt;
    kind_r   <= kind_nxt;
    lvl_r    <= lvl_nxt;
    tbyte_r  <= tbyte_nxt;
    tvalid_r <= tvalid_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = kind_r;
  assign out_led_level  = lvl_r;
  assign out_text_byte  = tbyte_r;
  assign out_text_valid = tvalid_r;
  assign out_last       = last_r;

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (state_r == ST_IDLE && !out_valid_r))
    else $error("item accepted while the sequencer is busy");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= lclp_pkg::LEN_W'(lclp_pkg::STORE_DEPTH))
    else $error("line length beyond store depth");

  a_discard_empty: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> (line_len_r == '0))
    else $error("characters stored while discarding");

  a_text_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_text_valid) |-> (out_event_kind == lclp_pkg::EV_TEXT))
    else $error("text character on a non-text result");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_kind != lclp_pkg::EV_TEXT) |-> out_last)
    else $error("status result without last mark");

endmodule

@@ hdl/lclp_ram.sv @@
// Generic single-port RAM with a registered read port.
// No dependencies.
module lclp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/lclp_cmp.sv @@
// Shared byte compare unit: checks one stored character against the
// keyword tables and against zero. Depends on lclp_pkg.
module lclp_cmp (
  input  logic [7:0]                 ch,
  input  logic [lclp_pkg::ADDR_W-1:0] idx,
  output lclp_pkg::cmp_res_t         res
);

  always_comb begin
    res.is_zero = (ch == lclp_pkg::CH_NUL);
    res.eq_on   = (ch == lclp_pkg::kw_on(idx));
    res.eq_off  = (ch == lclp_pkg::kw_off(idx));
    res.eq_tog  = (ch == lclp_pkg::kw_tog(idx));
  end

endmodule

@@ tb/line_command_led_parser_tb.sv @@
// Self-checking testbench for line_command_led_parser: sends serial byte items,
// predicts the LED, echo and overlong results and checks each one as it leaves.
// Depends on lclp_pkg and the line_command_led_parser RTL.
module line_command_led_parser_tb;

  typedef struct packed {
    lclp_pkg::event_kind_t kind;
    logic                  led;
    logic [7:0]            text;
    logic                  text_ok;
    logic                  last;
  } led_event_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_event_kind;
  logic       out_led_level;
  logic [7:0] out_text_byte;
  logic       out_text_valid;
  logic       out_last;

  led_event_t expected_events[$];
  logic [7:0] line_buf [lclp_pkg::STORE_DEPTH];
  int         line_len = 0;
  logic       skipping = 1'b0;
  logic       led_on = 1'b0;
  logic       quiet = 1'b0;
  int         errors = 0;
  int         bytes_sent = 0;
  int         events_seen = 0;
  int         overflows = 0;

  line_command_led_parser i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_kind(out_event_kind),
    .out_led_level (out_led_level),
    .out_text_byte (out_text_byte),
    .out_text_valid(out_text_valid),
    .out_last      (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(8 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void add_event(lclp_pkg::event_kind_t kind, logic [7:0] text,
                                    logic text_ok, logic last);
    led_event_t ev;
    ev.kind    = kind;
    ev.led     = led_on;
    ev.text    = text;
    ev.text_ok = text_ok;
    ev.last    = last;
    expected_events.push_back(ev);
  endfunction

  function automatic logic line_is(int n, string word);
    if (n != word.len()) return 1'b0;
    for (int i = 0; i < n; i++)
      if (line_buf[i] != word[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic track_rx_byte(input logic [7:0] c);
    int n;
    n = 0;
    if (c == lclp_pkg::CH_CR) return;
    if (skipping) begin
      if (c == lclp_pkg::CH_LF) skipping = 1'b0;
      return;
    end
    if (c != lclp_pkg::CH_LF) begin
      if (line_len >= lclp_pkg::STORE_DEPTH) begin
        line_len = 0;
        skipping = 1'b1;
        overflows++;
        add_event(lclp_pkg::EV_LONG, 8'd0, 1'b0, 1'b1);
      end else begin
        line_buf[line_len] = c;
        line_len++;
      end
      return;
    end
    while (n < line_len && line_buf[n] != lclp_pkg::CH_NUL) n++;
    line_len = 0;
    if (line_is(n, "ON")) begin
      led_on = 1'b1;
    end else if (line_is(n, "OFF")) begin
      led_on = 1'b0;
    end else if (line_is(n, "TOGGLE")) begin
      led_on = ~led_on;
    end else if (n == 0) begin
      add_event(lclp_pkg::EV_TEXT, 8'd0, 1'b0, 1'b1);
      return;
    end else begin
      for (int i = 0; i < n; i++)
        add_event(lclp_pkg::EV_TEXT, line_buf[i], 1'b1, i == n - 1);
      return;
    end
    add_event(lclp_pkg::EV_LED, 8'd0, 1'b0, 1'b1);
  endtask

  task automatic send_byte(input logic [7:0] c);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    if (c != lclp_pkg::CH_CR && !skipping) bytes_sent++;
    track_rx_byte(c);
    in_valid   <= 1'b1;
    in_rx_byte <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_events.size() != 0);
  endtask

  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == lclp_pkg::CH_LF);
    return c;
  endfunction

  always @(posedge clk) begin
    led_event_t ev;
    out_stall <= !quiet && ($urandom_range(99) < 11);
    if (rst_n && out_valid && !out_stall) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual kind %0d led %0b text %02h valid %0b last %0b",
                 $time, out_event_kind, out_led_level, out_text_byte, out_text_valid,
                 out_last);
      end else begin
        ev = expected_events.pop_front();
        if (out_event_kind !== ev.kind || out_led_level !== ev.led ||
            out_text_byte !== ev.text || out_text_valid !== ev.text_ok ||
            out_last !== ev.last) begin
          errors++;
          $display("%0t: mismatch, expected kind %0d led %0b text %02h valid %0b last %0b",
                   $time, ev.kind, ev.led, ev.text, ev.text_ok, ev.last);
          $display("%0t:           actual kind %0d led %0b text %02h valid %0b last %0b",
                   $time, out_event_kind, out_led_level, out_text_byte, out_text_valid,
                   out_last);
        end
      end
    end
  end

  task automatic test_commands();
    send_text("ON\r\n");
    send_text("TOGGLE\n");
    send_text("OFF\n");
  endtask

  task automatic test_special_lines();
    send_byte(lclp_pkg::CH_LF);
    send_byte(lclp_pkg::CH_CR);
    send_byte("A");
    send_byte(8'hFF);
    send_byte(lclp_pkg::CH_LF);
    send_byte("x");
    send_byte(lclp_pkg::CH_NUL);
    send_byte("y");
    send_byte(lclp_pkg::CH_LF);
  endtask

  task automatic send_command_line();
    string word;
    case ($urandom_range(2))
      0:       word = "ON";
      1:       word = "OFF";
      default: word = "TOGGLE";
    endcase
    for (int i = 0; i < word.len(); i++) begin
      if ($urandom_range(9) == 0) send_byte(lclp_pkg::CH_CR);
      send_byte(word[i]);
    end
    if ($urandom_range(4) == 0) begin
      send_byte(lclp_pkg::CH_NUL);
      repeat ($urandom_range(3)) send_byte(rand_text_char());
    end
    if ($urandom_range(2) == 0) send_byte(lclp_pkg::CH_CR);
    send_byte(lclp_pkg::CH_LF);
  endtask

  task automatic send_near_command_line();
    string word;
    int    cut;
    case ($urandom_range(2))
      0:       word = "ON";
      1:       word = "OFF";
      default: word = "TOGGLE";
    endcase
    cut = $urandom_range(word.len() - 1);
    case ($urandom_range(2))
      0: for (int i = 0; i < word.len(); i++) if (i != cut) send_byte(word[i]);
      1: begin
        send_text(word);
        send_byte(rand_text_char());
      end
      default: for (int i = 0; i < word.len(); i++)
        send_byte(i == cut ? word[i] ^ 8'h20 : word[i]);
    endcase
    send_byte(lclp_pkg::CH_LF);
  endtask

  task automatic send_text_line(input int n);
    repeat (n) send_byte(rand_text_char());
    send_byte(lclp_pkg::CH_LF);
  endtask

  task automatic send_overlong_line();
    repeat (lclp_pkg::STORE_DEPTH + 1 + $urandom_range(4)) send_byte(rand_text_char());
    send_byte(lclp_pkg::CH_CR);
    send_byte(lclp_pkg::CH_NUL);
    send_byte(lclp_pkg::CH_LF);
  endtask

  task automatic test_random_lines();
    int line_no;
    int pick;
    line_no = 0;
    while (bytes_sent < 230) begin
      quiet = (line_no >= 1 && line_no < 8);
      if (line_no == 8) wait_for_results();
      pick = $urandom_range(99);
      if (line_no == 0) send_overlong_line();
      else if (line_no == 1) send_text_line(lclp_pkg::STORE_DEPTH);
      else if (pick < 30) send_command_line();
      else if (pick < 58) send_text_line($urandom_range(8));
      else if (pick < 75) send_near_command_line();
      else if (pick < 80) send_text_line($urandom_range(20, lclp_pkg::STORE_DEPTH));
      else if (pick < 85) send_overlong_line();
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      line_no++;
    end
    quiet = 1'b0;
    send_byte(lclp_pkg::CH_LF);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_special_lines();
    wait_for_results();
    test_random_lines();
    wait_for_results();
    repeat (300) @(posedge clk);
    if (expected_events.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_events.size());
    end
    $display("Sent %0d byte items and checked %0d results, with %0d overlong lines,",
             bytes_sent, events_seen, overflows);
    $display("command, near-command, zero byte, empty and noise lines under random stalls.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lclp_pkg.sv
hdl/lclp_ram.sv
hdl/lclp_cmp.sv
hdl/line_command_led_parser.sv
tb/line_command_led_parser_tb.sv
